// File: rtl/tsoa_pkg.sv
// Shared types and codes for the three-stacks-in-one-memory unit.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package tsoa_pkg;

    localparam int IO_W = 32;

    typedef logic [1:0] t_status;
    typedef logic [1:0] t_sel;
    typedef logic       t_cmd;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_cmd CMD_PUSH = 1'b0;
    localparam t_cmd CMD_POP  = 1'b1;

    localparam t_sel SEL_LEFT  = 2'd0;
    localparam t_sel SEL_MID   = 2'd1;
    localparam t_sel SEL_RIGHT = 2'd2;
    localparam t_sel SEL_NONE  = 2'd3;

    localparam logic [IO_W-1:0] EMPTY_MARK = 32'h8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_MOVE,
        S_DONE
    } t_state;

endpackage

// File: rtl/three_stacks_one_array_unit.sv
// Top level: three stacks kept in one synchronous word memory.
// Depends on tsoa_pkg for codes, types and the state encoding.
`timescale 1ns / 1ps

// Usage:
// The input channel (i_in_valid / o_in_ready) carries one transaction per
// push or pop, addressed to the left, middle or right stack. Every input
// transaction yields exactly one output transaction (o_out_valid / i_out_ready)
// with the popped word and a status code: done, stack empty or memory full.
// A plain push or pop passes through the S_DONE or S_POP state and then the output
// register; no new input is taken until that state has handed its result on.
// A push that collides with a neighbouring stack first relocates the middle stack one
// word per cycle through the memory ports, then stores its own word; with no free word
// left it is refused as full. The memory's one read and one write port set this pace.
// The output register lets a new transaction be accepted while the previous
// result still waits; if the receiver stalls longer, the finished result is
// held internally and input stays blocked until it moves on.
// Synchronous reset empties all three stacks and drops the output valid; the
// memory contents are not cleared, and no word is read before it is written.
module three_stacks_one_array_unit #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tsoa_pkg::t_cmd                     i_command,
    input  tsoa_pkg::t_sel                     i_stack_select,
    input  logic signed [tsoa_pkg::IO_W-1:0]   i_push_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tsoa_pkg::IO_W-1:0]   o_pop_value,
    output tsoa_pkg::t_status                  o_status
);
    import tsoa_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 2) + 1;
    localparam logic signed [PW-1:0] P_DEPTH   = PW'(DEPTH);
    localparam logic signed [PW-1:0] P_ONE     = PW'(1);
    localparam logic signed [PW-1:0] P_MID_RST = PW'((DEPTH - 1) / 2);

    t_state r_state, n_state;

    logic signed [PW-1:0] r_lt, n_lt, r_mb, n_mb, r_mt, n_mt, r_rt, n_rt;
    logic signed [PW-1:0] r_mv_src, n_mv_src, r_mv_cnt, n_mv_cnt, r_mv_d, n_mv_d;
    logic                 r_mv_right, n_mv_right;
    logic                 r_wr_pend, n_wr_pend;
    logic [AW-1:0]        r_wr_addr, n_wr_addr;
    t_sel                 r_sel, n_sel;
    logic signed [IO_W-1:0] r_val, n_val;
    logic                 r_pop_hit, n_pop_hit;
    logic [IO_W-1:0]      r_res_value, n_res_value;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [IO_W-1:0]      r_out_value, n_out_value;
    t_status              r_out_status, n_out_status;

    logic [WORD_WIDTH-1:0]        mem [DEPTH];
    logic signed [WORD_WIDTH-1:0] r_rdata;

    logic                   mem_we, rd_en;
    logic [AW-1:0]          mem_waddr, rd_addr;
    logic [WORD_WIDTH-1:0]  mem_wdata;

    logic                   accept, in_push, sel_valid, collide, move_right, gap_ok;
    logic                   pop_ok, move_done, out_free, push_go, push_hit;
    logic signed [PW-1:0]   gap, d_step, pop_ptr, push_ptr;
    t_sel                   push_sel;
    logic signed [IO_W-1:0] push_src;
    logic [IO_W-1:0]        pop_word;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_out_value;
    assign o_status    = r_out_status;

    assign accept     = i_in_valid && o_in_ready;
    assign in_push    = (i_command == CMD_PUSH);
    assign sel_valid  = (i_stack_select != SEL_NONE);
    assign move_right = (i_stack_select == SEL_LEFT);
    assign gap        = move_right ? (r_rt - r_mt - P_ONE) : (r_mb - r_lt - P_ONE);
    assign gap_ok     = (gap > 0);
    assign d_step     = (gap + P_ONE) >>> 1;
    assign move_done  = (r_mv_cnt <= 0) && !r_wr_pend;
    assign out_free   = !r_out_valid || i_out_ready;
    assign pop_word   = r_pop_hit ? IO_W'(r_rdata) : '0;

    always_comb begin
        case (i_stack_select)
            SEL_LEFT: begin
                collide = (r_lt + P_ONE >= r_mb);
                pop_ok  = (r_lt >= 0);
                pop_ptr = r_lt;
            end
            SEL_MID: begin
                collide = (r_mt + P_ONE >= r_rt);
                pop_ok  = (r_mt >= r_mb);
                pop_ptr = r_mt;
            end
            SEL_RIGHT: begin
                collide = (r_rt - P_ONE <= r_mt);
                pop_ok  = (r_rt < P_DEPTH);
                pop_ptr = r_rt;
            end
            default: begin
                collide = 1'b0;
                pop_ok  = 1'b0;
                pop_ptr = r_rt;
            end
        endcase
    end

    assign push_go  = (r_state == S_IDLE && accept && in_push && sel_valid && !collide)
                   || (r_state == S_MOVE && move_done);
    assign push_sel = (r_state == S_IDLE) ? i_stack_select : r_sel;
    assign push_src = (r_state == S_IDLE) ? i_push_value : r_val;

    always_comb begin
        case (push_sel)
            SEL_LEFT: push_ptr = r_lt + P_ONE;
            SEL_MID:  push_ptr = r_mt + P_ONE;
            default:  push_ptr = r_rt - P_ONE;
        endcase
    end

    assign push_hit = (push_ptr >= 0) && (push_ptr < P_DEPTH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_push) begin
                        n_state = (sel_valid && collide && gap_ok) ? S_MOVE : S_DONE;
                    end else begin
                        n_state = pop_ok ? S_POP : S_DONE;
                    end
                end
            end
            S_POP:  n_state = out_free ? S_IDLE : S_DONE;
            S_MOVE: n_state = move_done ? S_DONE : S_MOVE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_lt         = r_lt;
        n_mb         = r_mb;
        n_mt         = r_mt;
        n_rt         = r_rt;
        n_mv_src     = r_mv_src;
        n_mv_cnt     = r_mv_cnt;
        n_mv_d       = r_mv_d;
        n_mv_right   = r_mv_right;
        n_wr_pend    = r_wr_pend;
        n_wr_addr    = r_wr_addr;
        n_sel        = r_sel;
        n_val        = r_val;
        n_pop_hit    = r_pop_hit;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_wr_addr;
        mem_wdata    = r_rdata;
        rd_en        = 1'b0;
        rd_addr      = r_mv_src[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sel        = i_stack_select;
                    n_val        = i_push_value;
                    n_res_value  = EMPTY_MARK;
                    n_res_status = ST_OK;
                    if (in_push) begin
                        if (!sel_valid) begin
                            n_res_status = ST_FULL;
                        end else if (collide) begin
                            if (!gap_ok) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_mv_right = move_right;
                                n_mv_d     = d_step;
                                n_wr_pend  = 1'b0;
                                n_mv_cnt   = r_mt - r_mb + P_ONE;
                                if (move_right) begin
                                    n_mb     = r_mb + d_step;
                                    n_mt     = r_mt + d_step;
                                    n_mv_src = r_mt;
                                end else begin
                                    n_mb     = r_mb - d_step;
                                    n_mt     = r_mt - d_step;
                                    n_mv_src = r_mb;
                                end
                            end
                        end
                    end else if (pop_ok) begin
                        rd_en     = 1'b1;
                        rd_addr   = pop_ptr[AW-1:0];
                        n_pop_hit = (pop_ptr >= 0) && (pop_ptr < P_DEPTH);
                        case (i_stack_select)
                            SEL_LEFT: n_lt = r_lt - P_ONE;
                            SEL_MID:  n_mt = r_mt - P_ONE;
                            default:  n_rt = r_rt + P_ONE;
                        endcase
                    end else begin
                        n_res_status = ST_EMPTY;
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = pop_word;
                    n_out_status = ST_OK;
                end else begin
                    n_res_value  = pop_word;
                    n_res_status = ST_OK;
                end
            end
            S_MOVE: begin
                if (r_wr_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_addr;
                    mem_wdata = r_rdata;
                end
                if (r_mv_cnt > 0) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_mv_src[AW-1:0];
                    n_wr_pend = 1'b1;
                    n_mv_cnt  = r_mv_cnt - P_ONE;
                    if (r_mv_right) begin
                        n_wr_addr = AW'(r_mv_src + r_mv_d);
                        n_mv_src  = r_mv_src - P_ONE;
                    end else begin
                        n_wr_addr = AW'(r_mv_src - r_mv_d);
                        n_mv_src  = r_mv_src + P_ONE;
                    end
                end else begin
                    n_wr_pend = 1'b0;
                end
                if (move_done) begin
                    n_res_value  = EMPTY_MARK;
                    n_res_status = ST_OK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                end
            end
            default: ;
        endcase

        if (push_go) begin
            case (push_sel)
                SEL_LEFT: n_lt = push_ptr;
                SEL_MID:  n_mt = push_ptr;
                default:  n_rt = push_ptr;
            endcase
            mem_we    = push_hit;
            mem_waddr = push_ptr[AW-1:0];
            mem_wdata = WORD_WIDTH'(push_src);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lt        <= -P_ONE;
            r_mb        <= P_MID_RST;
            r_mt        <= P_MID_RST - P_ONE;
            r_rt        <= P_DEPTH;
            r_mv_cnt    <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lt        <= n_lt;
            r_mb        <= n_mb;
            r_mt        <= n_mt;
            r_rt        <= n_rt;
            r_mv_cnt    <= n_mv_cnt;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_src     <= n_mv_src;
        r_mv_d       <= n_mv_d;
        r_mv_right   <= n_mv_right;
        r_wr_addr    <= n_wr_addr;
        r_sel        <= n_sel;
        r_val        <= n_val;
        r_pop_hit    <= n_pop_hit;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

// File: rtl/tsoa_checker.sv
// Port-level checker for the three-stacks unit and the bind that attaches it.
// Depends on tsoa_pkg and on the port list of three_stacks_one_array_unit.
`timescale 1ns / 1ps

module tsoa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input tsoa_pkg::t_cmd                   i_command,
    input tsoa_pkg::t_sel                   i_stack_select,
    input logic signed [tsoa_pkg::IO_W-1:0] i_push_value,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [tsoa_pkg::IO_W-1:0] o_pop_value,
    input tsoa_pkg::t_status                o_status
);
    import tsoa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pop_value)
            && $stable(o_status))
        else $error("Output transaction changed before it was taken.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK) || (o_status == ST_EMPTY)
            || (o_status == ST_FULL))
        else $error("Output status carries an undefined code.");

    a_fail_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_pop_value == EMPTY_MARK)
        else $error("A refused transaction returned a word other than the empty mark.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("A second transaction was accepted while one was in progress.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid survived reset.");

endmodule

bind three_stacks_one_array_unit tsoa_checker u_tsoa_checker (.*);

// File: sim/three_stacks_one_array_unit_tb.sv
// Testbench for three_stacks_one_array_unit: directed and random push/pop traffic
// with random idling on both handshakes, checked against a built-in stack predictor.
// Depends on rtl/tsoa_pkg.sv and rtl/three_stacks_one_array_unit.sv.
`timescale 1ns / 1ps

module three_stacks_one_array_unit_tb;
    import tsoa_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_OPS  = 1400;
    localparam int TAIL_OPS    = 120;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        t_cmd                   cmd;
        t_sel                   sel;
        logic signed [IO_W-1:0] word;
    } t_stack_op;

    typedef struct packed {
        logic signed [IO_W-1:0] word;
        t_status                status;
    } t_stack_reply;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    t_cmd                   i_command      = CMD_PUSH;
    t_sel                   i_stack_select = SEL_LEFT;
    logic signed [IO_W-1:0] i_push_value   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic signed [IO_W-1:0] o_pop_value;
    t_status                o_status;

    three_stacks_one_array_unit #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (IO_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_stack_select (i_stack_select),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pop_value    (o_pop_value),
        .o_status       (o_status)
    );

    // Predicted memory image and stack pointers.
    logic [IO_W-1:0] word_mem [DEPTH];
    int              left_sp  = -1;
    int              mid_lo   = (DEPTH - 1) / 2;
    int              mid_sp   = (DEPTH - 1) / 2 - 1;
    int              right_sp = DEPTH;

    t_stack_op    pending_ops[$];
    t_stack_reply expected_replies[$];
    t_stack_op    cur_op;
    int           total_ops     = 0;
    int           ops_sent      = 0;
    int           replies_seen  = 0;
    int           mismatches    = 0;
    int           send_gap      = 0;
    int           recv_gap      = 0;
    int           send_idle_pct = 20;
    int           recv_idle_pct = 20;
    int           stall_cycles  = 0;

    function automatic bit slide_middle(bit rightward);
        int gap;
        int step_len;
        gap = rightward ? (right_sp - mid_sp - 1) : (mid_lo - left_sp - 1);
        if (gap <= 0) begin
            return 1'b0;
        end
        step_len = (gap + 1) / 2;
        if (rightward) begin
            for (int i = mid_sp; i >= mid_lo; i--) begin
                word_mem[i + step_len] = word_mem[i];
            end
            mid_lo += step_len;
            mid_sp += step_len;
        end else begin
            for (int i = mid_lo; i <= mid_sp; i++) begin
                word_mem[i - step_len] = word_mem[i];
            end
            mid_lo -= step_len;
            mid_sp -= step_len;
        end
        return 1'b1;
    endfunction

    function automatic t_stack_reply apply_stack_op(t_stack_op op);
        t_stack_reply rep;
        rep.word   = EMPTY_MARK;
        rep.status = ST_OK;
        if (op.cmd == CMD_PUSH) begin
            case (op.sel)
                SEL_LEFT: begin
                    if (left_sp + 1 >= mid_lo && !slide_middle(1'b1)) begin
                        rep.status = ST_FULL;
                    end else begin
                        left_sp++;
                        word_mem[left_sp] = op.word;
                    end
                end
                SEL_MID: begin
                    if (mid_sp + 1 >= right_sp && !slide_middle(1'b0)) begin
                        rep.status = ST_FULL;
                    end else begin
                        mid_sp++;
                        word_mem[mid_sp] = op.word;
                    end
                end
                SEL_RIGHT: begin
                    if (right_sp - 1 <= mid_sp && !slide_middle(1'b0)) begin
                        rep.status = ST_FULL;
                    end else begin
                        right_sp--;
                        word_mem[right_sp] = op.word;
                    end
                end
                default: rep.status = ST_FULL;
            endcase
        end else begin
            rep.status = ST_EMPTY;
            case (op.sel)
                SEL_LEFT: begin
                    if (left_sp >= 0) begin
                        rep.word   = word_mem[left_sp];
                        rep.status = ST_OK;
                        left_sp--;
                    end
                end
                SEL_MID: begin
                    if (mid_sp >= mid_lo) begin
                        rep.word   = word_mem[mid_sp];
                        rep.status = ST_OK;
                        mid_sp--;
                    end
                end
                SEL_RIGHT: begin
                    if (right_sp < DEPTH) begin
                        rep.word   = word_mem[right_sp];
                        rep.status = ST_OK;
                        right_sp++;
                    end
                end
                default: rep.status = ST_EMPTY;
            endcase
        end
        return rep;
    endfunction

    function automatic t_stack_op random_op(int push_pct);
        t_stack_op op;
        op.cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
        op.sel = ($urandom_range(0, 31) == 0) ? SEL_NONE : t_sel'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0:       op.word = 32'sh7FFF_FFFF;
            1:       op.word = 32'sh8000_0000;
            2:       op.word = '0;
            3:       op.word = -32'sd1;
            default: op.word = $urandom;
        endcase
        return op;
    endfunction

    task automatic queue_op(t_cmd cmd, t_sel sel, logic signed [IO_W-1:0] word);
        t_stack_op op;
        op.cmd  = cmd;
        op.sel  = sel;
        op.word = word;
        pending_ops.push_back(op);
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        int run_len;
        int push_pct;

        // Empty pops, a push to the missing stack, then fill the whole memory so that
        // the middle stack is moved both ways, hit the full case, then pop each stack and the missing one.
        queue_op(CMD_POP, SEL_LEFT, '0);
        queue_op(CMD_POP, SEL_MID, '0);
        queue_op(CMD_POP, SEL_RIGHT, '0);
        queue_op(CMD_PUSH, SEL_NONE, 32'sh1234_5678);
        for (int i = 0; i < 8; i++) begin
            queue_op(CMD_PUSH, SEL_LEFT, (i == 0) ? 32'sh7FFF_FFFF : $urandom);
        end
        queue_op(CMD_PUSH, SEL_MID, 32'sh8000_0000);
        queue_op(CMD_PUSH, SEL_MID, -32'sd1);
        for (int i = 0; i < 6; i++) begin
            queue_op(CMD_PUSH, SEL_RIGHT, (i == 0) ? 32'sd0 : $urandom);
        end
        queue_op(CMD_PUSH, SEL_LEFT, 32'sh5555_5555);
        queue_op(CMD_PUSH, SEL_MID, 32'shAAAA_AAAA);
        queue_op(CMD_PUSH, SEL_RIGHT, 32'sh0F0F_F0F0);
        queue_op(CMD_POP, SEL_LEFT, '0);
        queue_op(CMD_POP, SEL_MID, '0);
        queue_op(CMD_POP, SEL_RIGHT, '0);
        queue_op(CMD_POP, SEL_NONE, -32'sd1);

        // Random runs each pick a push share at random, so the memory fills and drains.
        while (pending_ops.size() < 27 + RANDOM_OPS) begin
            run_len = $urandom_range(16, 64);
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 75;
                default: push_pct = 95;
            endcase
            repeat (run_len) pending_ops.push_back(random_op(push_pct));
        end
        total_ops = pending_ops.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_sent < total_ops || expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("three_stacks_one_array_unit verification clean");
        end else begin
            $display("three_stacks_one_array_unit verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_replies.push_back(apply_stack_op(cur_op));
                ops_sent++;
                if (ops_sent % 128 == 0) begin
                    send_idle_pct = 10 * $urandom_range(0, 3);
                end
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0 && total_ops - ops_sent > TAIL_OPS
                             && $urandom_range(1, 100) <= send_idle_pct) begin
                    send_gap = $urandom_range(0, 8);
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    cur_op = pending_ops.pop_front();
                    i_command      <= cur_op.cmd;
                    i_stack_select <= cur_op.sel;
                    i_push_value   <= cur_op.word;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_stack_reply exp_rep;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                replies_seen++;
                if (replies_seen % 128 == 0) begin
                    recv_idle_pct = 10 * $urandom_range(0, 3);
                end
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected transaction: pop_value %h status %0d",
                                 o_pop_value, o_status);
                    end
                end else begin
                    exp_rep = expected_replies.pop_front();
                    if (o_pop_value !== exp_rep.word || o_status !== exp_rep.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch on result %0d: pop_value %h/%h status %0d/%0d",
                                     replies_seen, exp_rep.word, o_pop_value,
                                     exp_rep.status, o_status);
                        end
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else if (total_ops - replies_seen > TAIL_OPS
                         && $urandom_range(1, 100) <= recv_idle_pct) begin
                recv_gap = $urandom_range(0, 8);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("three_stacks_one_array_unit verification failed");
                $finish;
            end
        end
    end

endmodule
